/* rtl/core/blr_pkg.sv */
// ----------------------------------------------------------------------------
// blr_pkg
// Shared codes for the block link resolver: token opcodes, stack entry kinds
// and result kinds.
// ----------------------------------------------------------------------------
package blr_pkg;

   localparam int OPC_W  = 4;
   localparam int KIND_W = 3;
   localparam int RES_W  = 3;

   // token opcodes
   localparam logic [OPC_W-1:0] OP_IF    = 4'd1;
   localparam logic [OPC_W-1:0] OP_DO    = 4'd5;
   localparam logic [OPC_W-1:0] OP_END   = 4'd6;
   localparam logic [OPC_W-1:0] OP_SKIP  = 4'd7;
   localparam logic [OPC_W-1:0] OP_LEAVE = 4'd8;

   // kinds held in a stack entry (low bits of the pushing opcode)
   localparam logic [KIND_W-1:0] KIND_IF    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ELSE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WHILE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DO    = 3'd5;

   // result kinds
   localparam logic [RES_W-1:0] RES_LINK     = 3'd0;
   localparam logic [RES_W-1:0] RES_OK       = 3'd1;
   localparam logic [RES_W-1:0] RES_UNCLOSED = 3'd2;
   localparam logic [RES_W-1:0] RES_UNDER    = 3'd3;
   localparam logic [RES_W-1:0] RES_PAIR     = 3'd4;
   localparam logic [RES_W-1:0] RES_TOOMANY  = 3'd5;

endpackage

/* rtl/core/block_link_resolver_core.sv */
// ----------------------------------------------------------------------------
// block_link_resolver_core
// Resolves block links for a stream of classified tokens using a bounded
// stack of open blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (req_opcode, req_last_token), one token each,
//   taken when req_valid is high and req_stall is low. Tokens are numbered
//   from 0 in arrival order. Results leave on rsp_* one per cycle while
//   rsp_stall is low: link writes, one error, or the closing status on the last
//   token. rsp_last marks the final result of a request.
//   Timing: a request that causes no result and pushes or leaves the stack
//   alone leaves req_stall low. Each result waits in the result queue; an
//   end token that pops also reloads the two cached top entries from the
//   stack memory through its two read ports, overlapped with the queue.
//   The first result passes through the result queue and then the output
//   register before it shows on rsp_*; a status that waits on a refill
//   enters the queue only once the refill is done.
//   The top two stack entries live in registers; the memory read is
//   registered, so a pop is followed by a refill of both.
//   Reset clears count, positions and error state; the stack memory is not
//   cleared since only entries below the count are ever used.
//   A stalled rsp_* holds its result; results behind it wait in the queue
//   and req_stall stays high until the queue has drained.
// ----------------------------------------------------------------------------
module block_link_resolver_core #(
   parameter int STACK_DEPTH   = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [blr_pkg::OPC_W-1:0]  req_opcode,
   input  logic                       req_last_token,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [blr_pkg::RES_W-1:0]  rsp_result_kind,
   output logic [POSITION_BITS-1:0]   rsp_link_at,
   output logic [POSITION_BITS:0]     rsp_link_to,
   output logic                       rsp_last
);

   import blr_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = AW + 1;
   localparam int PB = POSITION_BITS;
   localparam int EW = PB + KIND_W;
   localparam int SW = RES_W + PB + PB + 1 + 1;
   localparam logic [CW-1:0] DEPTH_C   = CW'(STACK_DEPTH);
   localparam logic [PB:0]   POS_LIMIT = {1'b1, {PB{1'b0}}};

   function automatic logic [SW-1:0] mk_slot(input logic [RES_W-1:0] kind,
                                             input logic [PB-1:0] at,
                                             input logic [PB:0] to);
      mk_slot = {kind, at, to, 1'b0};
   endfunction

   // architectural state
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [EW-1:0]    t0_ff, t0_in;
   logic [EW-1:0]    t1_ff, t1_in;
   logic [PB:0]      pos_ff, pos_in;
   logic [PB-1:0]    proc_ff, proc_in;
   logic             err_ff, err_in;
   // refill and deferred status
   logic             fill_ff, fill_in;
   logic             stat_ff, stat_in;
   logic             stat_ok_ff, stat_ok_in;
   // result queue and output register
   logic [SW-1:0]    pend_ff [3];
   logic [SW-1:0]    pend_in [3];
   logic [1:0]       pend_cnt_ff, pend_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_slot_ff, rsp_slot_in;

   // memory ports
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic [AW-1:0]    rd_addr0;
   logic [AW-1:0]    rd_addr1;
   logic [EW-1:0]    rd_data0;
   logic [EW-1:0]    rd_data1;

   // token decode
   logic             accept;
   logic             drain;
   logic [1:0]       ex_n;
   logic [SW-1:0]    ex_r0;
   logic [SW-1:0]    ex_r1;
   logic             ex_err;
   logic             ex_pop;
   logic             ex_push;
   logic             ex_skip;
   logic             ex_stat;
   logic [CW-1:0]    ex_cnt;
   logic [CW-1:0]    cnt_m1;
   logic [CW-1:0]    cnt_m2;
   logic [SW-1:0]    stat_now;
   logic [SW-1:0]    stat_late;
   logic [SW-1:0]    last_bit;

   logic [PB-1:0]     pos_lo;
   logic [PB:0]       pos_p1;
   logic [PB-1:0]     t0_pos;
   logic [PB-1:0]     t1_pos;
   logic [KIND_W-1:0] t0_kind;
   logic [KIND_W-1:0] t1_kind;

   blr_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (EW)
   ) u_stack (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   assign req_stall = fill_ff | (pend_cnt_ff != 2'd0);
   assign accept    = req_valid & ~req_stall;
   assign drain     = (pend_cnt_ff != 2'd0) & (~rsp_valid_ff | ~rsp_stall);

   assign pos_lo  = pos_ff[PB-1:0];
   assign pos_p1  = pos_ff + (PB+1)'(1);
   assign t0_pos  = t0_ff[EW-1:KIND_W];
   assign t1_pos  = t1_ff[EW-1:KIND_W];
   assign t0_kind = t0_ff[KIND_W-1:0];
   assign t1_kind = t1_ff[KIND_W-1:0];

   assign wr_addr  = cnt_ff[AW-1:0];
   assign wr_data  = {pos_lo, req_opcode[KIND_W-1:0]};
   assign cnt_m1   = ex_cnt - CW'(1);
   assign cnt_m2   = ex_cnt - CW'(2);
   assign rd_addr0 = cnt_m1[AW-1:0];
   assign rd_addr1 = cnt_m2[AW-1:0];
   assign last_bit = {{(SW-1){1'b0}}, 1'b1};

   // decode one token against the cached top entries
   always_comb begin
      ex_n    = 2'd0;
      ex_r0   = '0;
      ex_r1   = '0;
      ex_err  = 1'b0;
      ex_pop  = 1'b0;
      ex_push = 1'b0;
      ex_skip = 1'b0;
      ex_cnt  = cnt_ff;
      if (!err_ff) begin
         if (pos_ff == POS_LIMIT) begin
            ex_err = 1'b1;
            ex_n   = 2'd1;
            ex_r0  = mk_slot(RES_TOOMANY, {PB{1'b1}}, '0);
         end else if (req_opcode == OP_SKIP) begin
            ex_skip = 1'b1;
         end else if (req_opcode == OP_LEAVE) begin
            ex_n  = 2'd1;
            ex_r0 = mk_slot(RES_LINK, proc_ff, pos_ff);
         end else if (req_opcode >= OP_IF && req_opcode <= OP_DO) begin
            if (cnt_ff >= DEPTH_C) begin
               ex_err = 1'b1;
               ex_n   = 2'd1;
               ex_r0  = mk_slot(RES_PAIR, pos_lo, '0);
            end else begin
               ex_push = 1'b1;
               ex_cnt  = cnt_ff + CW'(1);
            end
         end else if (req_opcode == OP_END) begin
            if (cnt_ff == '0) begin
               ex_err = 1'b1;
               ex_n   = 2'd1;
               ex_r0  = mk_slot(RES_UNDER, pos_lo, '0);
            end else begin
               case (t0_kind)
                  KIND_DO: begin
                     if (cnt_ff < CW'(2)) begin
                        ex_err = 1'b1;
                        ex_n   = 2'd1;
                        ex_r0  = mk_slot(RES_UNDER, pos_lo, '0);
                     end else if (t1_kind == KIND_IF) begin
                        ex_n   = 2'd1;
                        ex_r0  = mk_slot(RES_LINK, t0_pos, pos_ff);
                        ex_pop = 1'b1;
                        ex_cnt = cnt_ff - CW'(2);
                     end else if (t1_kind == KIND_WHILE) begin
                        ex_n   = 2'd2;
                        ex_r0  = mk_slot(RES_LINK, pos_lo, {1'b0, t1_pos} + (PB+1)'(1));
                        ex_r1  = mk_slot(RES_LINK, t0_pos, pos_p1);
                        ex_pop = 1'b1;
                        ex_cnt = cnt_ff - CW'(2);
                     end else begin
                        ex_err = 1'b1;
                        ex_n   = 2'd1;
                        ex_r0  = mk_slot(RES_PAIR, pos_lo, '0);
                     end
                  end
                  KIND_ELSE: begin
                     if (cnt_ff < CW'(3)) begin
                        ex_err = 1'b1;
                        ex_n   = 2'd1;
                        ex_r0  = mk_slot(RES_UNDER, pos_lo, '0);
                     end else begin
                        // else -> end+1, do -> else+1, drop the if entry
                        ex_n   = 2'd2;
                        ex_r0  = mk_slot(RES_LINK, t0_pos, pos_p1);
                        ex_r1  = mk_slot(RES_LINK, t1_pos, {1'b0, t0_pos} + (PB+1)'(1));
                        ex_pop = 1'b1;
                        ex_cnt = cnt_ff - CW'(3);
                     end
                  end
                  default: begin
                     ex_pop = 1'b1;
                     ex_cnt = cnt_ff - CW'(1);
                  end
               endcase
            end
         end
      end
   end

   assign ex_stat = req_last_token & ~err_ff & ~ex_err;

   // status when the top is already known, and status after a refill
   always_comb begin
      if (ex_cnt == '0) begin
         stat_now = mk_slot(RES_OK, '0, '0) | last_bit;
      end else if (ex_push) begin
         stat_now = mk_slot(RES_UNCLOSED, pos_lo, '0) | last_bit;
      end else begin
         stat_now = mk_slot(RES_UNCLOSED, t0_pos, '0) | last_bit;
      end
      if (stat_ok_ff) begin
         stat_late = mk_slot(RES_OK, '0, '0) | last_bit;
      end else begin
         stat_late = mk_slot(RES_UNCLOSED, rd_data0[EW-1:KIND_W], '0) | last_bit;
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      pos_in       = pos_ff;
      proc_in      = proc_ff;
      err_in       = err_ff;
      fill_in      = 1'b0;
      stat_in      = stat_ff;
      stat_ok_in   = stat_ok_ff;
      pend_in      = pend_ff;
      pend_cnt_in  = pend_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      wr_en        = 1'b0;

      // advance the output register
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = pend_cnt_ff != 2'd0;
         rsp_slot_in  = pend_ff[0];
      end
      if (drain) begin
         pend_in[0]  = pend_ff[1];
         pend_in[1]  = pend_ff[2];
         pend_cnt_in = pend_cnt_ff - 2'd1;
      end

      // reload the cached top entries after a pop
      if (fill_ff) begin
         t0_in   = rd_data0;
         t1_in   = rd_data1;
         stat_in = 1'b0;
         if (stat_ff) begin
            case (pend_cnt_in)
               2'd0:    pend_in[0] = stat_late;
               2'd1:    pend_in[1] = stat_late;
               default: pend_in[2] = stat_late;
            endcase
            pend_cnt_in = pend_cnt_in + 2'd1;
         end
      end

      if (accept) begin
         // queue is empty here: fill it from the front
         case (ex_n)
            2'd0: begin
               pend_in[0]  = stat_now;
               pend_cnt_in = (ex_stat && !ex_pop) ? 2'd1 : 2'd0;
            end
            2'd1: begin
               pend_in[0]  = ex_r0 | (ex_stat ? '0 : last_bit);
               pend_in[1]  = stat_now;
               pend_cnt_in = (ex_stat && !ex_pop) ? 2'd2 : 2'd1;
            end
            default: begin
               pend_in[0]  = ex_r0;
               pend_in[1]  = ex_r1 | (ex_stat ? '0 : last_bit);
               pend_in[2]  = stat_now;
               pend_cnt_in = (ex_stat && !ex_pop) ? 2'd3 : 2'd2;
            end
         endcase

         if (ex_push) begin
            wr_en = 1'b1;
            t1_in = t0_ff;
            t0_in = wr_data;
         end
         if (ex_err) begin
            err_in = 1'b1;
         end
         if (ex_skip) begin
            proc_in = pos_lo;
         end
         cnt_in     = ex_cnt;
         fill_in    = ex_pop;
         stat_in    = ex_stat & ex_pop;
         stat_ok_in = ex_cnt == '0;
         pos_in     = (pos_ff == POS_LIMIT) ? pos_ff : pos_p1;

         // end of program: clear count, positions and error state
         if (req_last_token) begin
            cnt_in  = '0;
            pos_in  = '0;
            proc_in = '0;
            err_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pos_ff       <= '0;
         proc_ff      <= '0;
         err_ff       <= 1'b0;
         fill_ff      <= 1'b0;
         stat_ff      <= 1'b0;
         pend_cnt_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         proc_ff      <= proc_in;
         err_ff       <= err_in;
         fill_ff      <= fill_in;
         stat_ff      <= stat_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      stat_ok_ff  <= stat_ok_in;
      pend_ff     <= pend_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_slot_ff[SW-1 -: RES_W];
   assign rsp_link_at     = rsp_slot_ff[2*PB+1 -: PB];
   assign rsp_link_to     = rsp_slot_ff[PB+1 -: PB+1];
   assign rsp_last        = rsp_slot_ff[0];

endmodule

/* rtl/core/blr_stack_mem.sv */
// ----------------------------------------------------------------------------
// blr_stack_mem
// Block stack storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module blr_stack_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 19
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] stack_ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ram_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= stack_ram_ff[rd_addr0];
      rd_data1_ff <= stack_ram_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule
